/* hw/rtl/illm_pkg.sv */
// Shared types and constants of the indexed linked list manager.
package illm_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int OP_W          = 3;
    localparam int SLOT_W        = 6;
    localparam int POS_W         = 6;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = 48;
    localparam int OUT_DATA_W    = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_PUSH     = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_FIND     = 3'd3,
        OP_READ     = 3'd4,
        OP_READ_POS = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD       = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FULL,
        RES_BAD,
        RES_NOT_FOUND,
        RES_SLOT,
        RES_VALUE,
        RES_FOUND
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_A,
        ST_INS_B,
        ST_RM_A,
        ST_RD_A,
        ST_FIND,
        ST_POS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic walk_init;
        logic walk_step;
        logic ins_a;
        logic ins_b;
        logic rm_a;
        logic res_set;
        res_t res;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic slot_ok;
        logic after_ok;
        logic full;
        logic cur_zero;
        logic match;
        logic cnt_zero;
        logic out_busy;
    } stat_t;

endpackage

/* hw/rtl/illm_ctrl.sv */
// Controller state machine that sequences each list operation.
module illm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  illm_pkg::stat_t     stat,
    output illm_pkg::cmd_t      cmd
);

    illm_pkg::state_t state_reg;
    illm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= illm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            illm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = illm_pkg::ST_DECODE;
                end
            end
            illm_pkg::ST_DECODE:
            begin
                unique case (stat.op)
                    illm_pkg::OP_INSERT:
                    begin
                        if (stat.after_ok && !stat.full)
                        begin
                            state_next = illm_pkg::ST_INS_A;
                        end
                        else
                        begin
                            state_next = illm_pkg::ST_DONE;
                        end
                    end
                    illm_pkg::OP_PUSH:
                    begin
                        state_next = stat.full ? illm_pkg::ST_DONE : illm_pkg::ST_INS_A;
                    end
                    illm_pkg::OP_REMOVE:
                    begin
                        state_next = stat.slot_ok ? illm_pkg::ST_RM_A : illm_pkg::ST_DONE;
                    end
                    illm_pkg::OP_READ:
                    begin
                        state_next = stat.slot_ok ? illm_pkg::ST_RD_A : illm_pkg::ST_DONE;
                    end
                    illm_pkg::OP_FIND:     state_next = illm_pkg::ST_FIND;
                    illm_pkg::OP_READ_POS: state_next = illm_pkg::ST_POS;
                    default:               state_next = illm_pkg::ST_DONE;
                endcase
            end
            illm_pkg::ST_INS_A: state_next = illm_pkg::ST_INS_B;
            illm_pkg::ST_INS_B: state_next = illm_pkg::ST_DONE;
            illm_pkg::ST_RM_A:  state_next = illm_pkg::ST_DONE;
            illm_pkg::ST_RD_A:  state_next = illm_pkg::ST_DONE;
            illm_pkg::ST_FIND:
            begin
                if (stat.cur_zero || stat.match)
                begin
                    state_next = illm_pkg::ST_DONE;
                end
            end
            illm_pkg::ST_POS:
            begin
                if (stat.cnt_zero)
                begin
                    state_next = illm_pkg::ST_DONE;
                end
            end
            illm_pkg::ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = illm_pkg::ST_IDLE;
                end
            end
            default: state_next = illm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.res = illm_pkg::RES_ZERO;
        unique case (state_reg)
            illm_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = in_valid;
            end
            illm_pkg::ST_DECODE:
            begin
                unique case (stat.op)
                    illm_pkg::OP_INSERT:
                    begin
                        if (!stat.after_ok)
                        begin
                            cmd.res_set = 1'b1;
                            cmd.res     = illm_pkg::RES_BAD;
                        end
                        else if (stat.full)
                        begin
                            cmd.res_set = 1'b1;
                            cmd.res     = illm_pkg::RES_FULL;
                        end
                    end
                    illm_pkg::OP_PUSH:
                    begin
                        cmd.res_set = stat.full;
                        cmd.res     = illm_pkg::RES_FULL;
                    end
                    illm_pkg::OP_REMOVE, illm_pkg::OP_READ:
                    begin
                        cmd.res_set = !stat.slot_ok;
                        cmd.res     = illm_pkg::RES_BAD;
                    end
                    illm_pkg::OP_FIND, illm_pkg::OP_READ_POS:
                    begin
                        cmd.walk_init = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res     = illm_pkg::RES_ZERO;
                    end
                endcase
            end
            illm_pkg::ST_INS_A:
            begin
                cmd.ins_a = 1'b1;
            end
            illm_pkg::ST_INS_B:
            begin
                cmd.ins_b   = 1'b1;
                cmd.res_set = 1'b1;
                cmd.res     = illm_pkg::RES_SLOT;
            end
            illm_pkg::ST_RM_A:
            begin
                cmd.rm_a    = 1'b1;
                cmd.res_set = 1'b1;
                cmd.res     = illm_pkg::RES_VALUE;
            end
            illm_pkg::ST_RD_A:
            begin
                cmd.res_set = 1'b1;
                cmd.res     = illm_pkg::RES_VALUE;
            end
            illm_pkg::ST_FIND:
            begin
                if (stat.cur_zero)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res     = illm_pkg::RES_NOT_FOUND;
                end
                else if (stat.match)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res     = illm_pkg::RES_FOUND;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            illm_pkg::ST_POS:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res     = stat.cur_zero ? illm_pkg::RES_NOT_FOUND
                                                : illm_pkg::RES_VALUE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            illm_pkg::ST_DONE:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/illm_datapath.sv */
// Datapath: slot store, free-slot FIFO, link walker and result registers.
module illm_datapath #(
    parameter int NUM_SLOTS = illm_pkg::NUM_SLOTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  illm_pkg::cmd_t                     cmd,
    output illm_pkg::stat_t                    stat,
    input  logic [illm_pkg::OP_W-1:0]          in_opcode,
    input  logic [illm_pkg::SLOT_W-1:0]        in_slot,
    input  logic [illm_pkg::POS_W-1:0]         in_position,
    input  logic signed [illm_pkg::VALUE_W-1:0] in_value,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [illm_pkg::VALUE_W-1:0] out_value,
    output logic [illm_pkg::SLOT_W-1:0]        out_slot,
    output logic [illm_pkg::POS_W-1:0]         out_position,
    output logic [illm_pkg::STATUS_W-1:0]      out_status
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int EXT_W = IDX_W + illm_pkg::SLOT_W;
    localparam logic [IDX_W:0] SIZE_W = (IDX_W + 1)'(NUM_SLOTS);

    // Slot store; slot 0 is the sentinel, whose links live in head_reg and tail_reg.
    logic signed [illm_pkg::VALUE_W-1:0] value_mem [NUM_SLOTS];
    logic [IDX_W-1:0] next_mem [NUM_SLOTS];
    logic [IDX_W-1:0] prev_mem [NUM_SLOTS];
    logic [IDX_W-1:0] fifo_mem [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] in_use_reg;
    logic [NUM_SLOTS-1:0] fifo_written_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] fifo_head_reg;
    logic [IDX_W-1:0] free_count_reg;

    illm_pkg::op_t op_reg;
    logic [illm_pkg::SLOT_W-1:0] slot_reg;
    logic [illm_pkg::POS_W-1:0]  pos_cnt_reg;
    logic signed [illm_pkg::VALUE_W-1:0] val_reg;

    logic signed [illm_pkg::VALUE_W-1:0] value_rd_reg;
    logic [IDX_W-1:0] next_rd_reg;
    logic [IDX_W-1:0] prev_rd_reg;
    logic [IDX_W-1:0] fifo_rd_reg;
    logic             fifo_rd_written_reg;

    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] ord_reg;
    logic [IDX_W-1:0] new_slot_reg;
    logic [IDX_W-1:0] succ_reg;

    logic signed [illm_pkg::VALUE_W-1:0] res_value_reg;
    logic [illm_pkg::SLOT_W-1:0]   res_slot_reg;
    logic [illm_pkg::POS_W-1:0]    res_pos_reg;
    illm_pkg::status_t             res_status_reg;

    logic                                out_valid_reg;
    logic signed [illm_pkg::VALUE_W-1:0] out_value_reg;
    logic [illm_pkg::SLOT_W-1:0]         out_slot_reg;
    logic [illm_pkg::POS_W-1:0]          out_pos_reg;
    illm_pkg::status_t                   out_status_reg;

    logic [EXT_W-1:0] slot_ext;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_in_range;
    logic [IDX_W-1:0] target_idx;
    logic [IDX_W-1:0] walk_next;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] alloc_slot;
    logic [IDX_W-1:0] alloc_succ;
    logic [IDX_W:0]   head_inc;
    logic [IDX_W-1:0] head_wrap;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] fifo_tail;

    function automatic logic [illm_pkg::SLOT_W-1:0] to_field(input logic [IDX_W-1:0] x);
        logic [EXT_W-1:0] w;
        w = {{illm_pkg::SLOT_W{1'b0}}, x};
        return w[illm_pkg::SLOT_W-1:0];
    endfunction

    assign slot_ext      = {{IDX_W{1'b0}}, slot_reg};
    assign slot_idx      = slot_ext[IDX_W-1:0];
    assign slot_in_range = slot_ext < EXT_W'(NUM_SLOTS);

    always_comb
    begin
        priority if (op_reg == illm_pkg::OP_PUSH)
        begin
            target_idx = tail_reg;
        end
        else if (op_reg == illm_pkg::OP_FIND)
        begin
            target_idx = head_reg;
        end
        else
        begin
            target_idx = slot_idx;
        end
    end

    assign walk_next = (cur_reg == '0) ? head_reg : next_rd_reg;
    assign rd_addr   = cmd.walk_step ? walk_next : target_idx;

    // A FIFO entry that was never written is read as the slot one past its position.
    assign head_inc   = {1'b0, fifo_head_reg} + (IDX_W + 1)'(1);
    assign head_wrap  = (head_inc == SIZE_W) ? '0 : head_inc[IDX_W-1:0];
    assign alloc_slot = fifo_rd_written_reg ? fifo_rd_reg : head_inc[IDX_W-1:0];
    assign alloc_succ = (target_idx == '0) ? head_reg : next_rd_reg;
    assign tail_sum   = {1'b0, fifo_head_reg} + {1'b0, free_count_reg};
    always_comb
    begin
        if (tail_sum >= SIZE_W)
        begin
            fifo_tail = IDX_W'(tail_sum - SIZE_W);
        end
        else
        begin
            fifo_tail = tail_sum[IDX_W-1:0];
        end
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.slot_ok  = slot_in_range && in_use_reg[slot_idx] && (slot_reg != '0);
        stat.after_ok = slot_in_range && in_use_reg[slot_idx];
        stat.full     = (free_count_reg == '0);
        stat.cur_zero = (cur_reg == '0);
        stat.match    = (value_rd_reg == val_reg);
        stat.cnt_zero = (pos_cnt_reg == '0);
        stat.out_busy = out_valid_reg && !out_ready;
    end

    // Memory reads, registered every cycle.
    always_ff @(posedge clk)
    begin
        value_rd_reg <= value_mem[rd_addr];
        next_rd_reg  <= next_mem[rd_addr];
        prev_rd_reg  <= prev_mem[rd_addr];
        fifo_rd_reg  <= fifo_mem[fifo_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_a)
        begin
            value_mem[alloc_slot] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_a)
        begin
            next_mem[alloc_slot] <= alloc_succ;
        end
        else if (cmd.ins_b && target_idx != '0)
        begin
            next_mem[target_idx] <= new_slot_reg;
        end
        else if (cmd.rm_a && prev_rd_reg != '0)
        begin
            next_mem[prev_rd_reg] <= next_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_a)
        begin
            prev_mem[alloc_slot] <= target_idx;
        end
        else if (cmd.ins_b && succ_reg != '0)
        begin
            prev_mem[succ_reg] <= new_slot_reg;
        end
        else if (cmd.rm_a && next_rd_reg != '0)
        begin
            prev_mem[next_rd_reg] <= prev_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rm_a)
        begin
            fifo_mem[fifo_tail] <= slot_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= illm_pkg::op_t'(in_opcode);
            slot_reg <= in_slot;
            val_reg  <= in_value;
        end
        if (cmd.load)
        begin
            pos_cnt_reg <= in_position;
        end
        else if (cmd.walk_step)
        begin
            pos_cnt_reg <= pos_cnt_reg - illm_pkg::POS_W'(1);
        end
        if (cmd.walk_init)
        begin
            cur_reg <= (op_reg == illm_pkg::OP_FIND) ? head_reg : '0;
            ord_reg <= IDX_W'(1);
        end
        else if (cmd.walk_step)
        begin
            cur_reg <= walk_next;
            ord_reg <= ord_reg + IDX_W'(1);
        end
        if (cmd.ins_a)
        begin
            new_slot_reg <= alloc_slot;
            succ_reg     <= alloc_succ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg          <= NUM_SLOTS'(1);
            fifo_written_reg    <= '0;
            fifo_rd_written_reg <= 1'b0;
            head_reg            <= '0;
            tail_reg            <= '0;
            fifo_head_reg       <= '0;
            free_count_reg      <= IDX_W'(NUM_SLOTS - 1);
        end
        else
        begin
            fifo_rd_written_reg <= fifo_written_reg[fifo_head_reg];
            if (cmd.ins_a)
            begin
                in_use_reg[alloc_slot] <= 1'b1;
                fifo_head_reg          <= head_wrap;
                free_count_reg         <= free_count_reg - IDX_W'(1);
            end
            if (cmd.ins_b)
            begin
                if (target_idx == '0)
                begin
                    head_reg <= new_slot_reg;
                end
                if (succ_reg == '0)
                begin
                    tail_reg <= new_slot_reg;
                end
            end
            if (cmd.rm_a)
            begin
                if (prev_rd_reg == '0)
                begin
                    head_reg <= next_rd_reg;
                end
                if (next_rd_reg == '0)
                begin
                    tail_reg <= prev_rd_reg;
                end
                in_use_reg[slot_idx]        <= 1'b0;
                fifo_written_reg[fifo_tail] <= 1'b1;
                free_count_reg              <= free_count_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            res_value_reg  <= '0;
            res_slot_reg   <= '0;
            res_pos_reg    <= '0;
            res_status_reg <= illm_pkg::STATUS_OK;
            unique case (cmd.res)
                illm_pkg::RES_ZERO:      res_status_reg <= illm_pkg::STATUS_OK;
                illm_pkg::RES_FULL:      res_status_reg <= illm_pkg::STATUS_FULL;
                illm_pkg::RES_BAD:       res_status_reg <= illm_pkg::STATUS_BAD;
                illm_pkg::RES_NOT_FOUND: res_status_reg <= illm_pkg::STATUS_NOT_FOUND;
                illm_pkg::RES_SLOT:      res_slot_reg   <= to_field(new_slot_reg);
                illm_pkg::RES_VALUE:     res_value_reg  <= value_rd_reg;
                illm_pkg::RES_FOUND:
                begin
                    res_slot_reg <= to_field(cur_reg);
                    res_pos_reg  <= to_field(ord_reg);
                end
                default:                 res_status_reg <= illm_pkg::STATUS_OK;
            endcase
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_slot_reg   <= res_slot_reg;
            out_pos_reg    <= res_pos_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_slot     = out_slot_reg;
    assign out_position = out_pos_reg;
    assign out_status   = out_status_reg;

endmodule

/* hw/rtl/indexed_linked_list_manager.sv */
// Top level of the indexed linked list manager.
// A circular doubly linked list lives in a store of NUM_SLOTS slots, slot 0 being the
// sentinel, with free slots handed out from a FIFO. Each input item is one operation and
// gives exactly one result item; one item is worked on at a time. After decode, insert and
// push pass through ST_INS_A and ST_INS_B, read slot and remove through ST_RD_A or ST_RM_A,
// and a rejected or unused operation goes straight to ST_DONE; find walks the list until a
// match or the end of the list, and read position walks it for the given position, each link
// followed being one registered read of the slot store. The result sits in an output
// register, so the block takes the next item in the same cycle its result is offered; a
// result that is not taken holds the following one back.
module indexed_linked_list_manager #(
    parameter int NUM_SLOTS = illm_pkg::NUM_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: slot[5:0], position[11:6], value[43:12], zero fill.
    input  logic [illm_pkg::IN_DATA_W-1:0]      s_tdata,
    // Fields from bit 0: opcode[2:0].
    input  logic [illm_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: out_value[31:0], out_slot[37:32], out_position[43:38], zero fill.
    output logic [illm_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [illm_pkg::STATUS_W-1:0]       m_tuser
);

    illm_pkg::cmd_t  cmd;
    illm_pkg::stat_t stat;

    logic signed [illm_pkg::VALUE_W-1:0] out_value;
    logic [illm_pkg::SLOT_W-1:0]         out_slot;
    logic [illm_pkg::POS_W-1:0]          out_position;

    illm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    illm_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_opcode    (s_tuser),
        .in_slot      (s_tdata[5:0]),
        .in_position  (s_tdata[11:6]),
        .in_value     (s_tdata[43:12]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_value    (out_value),
        .out_slot     (out_slot),
        .out_position (out_position),
        .out_status   (m_tuser)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = {4'b0000, out_position, out_slot, out_value};

endmodule

/* verif/indexed_linked_list_manager_tb.sv */
// Self-checking testbench for the indexed linked list manager.
`timescale 1ns / 1ps

module indexed_linked_list_manager_tb;

    localparam int NSLOT = 64;
    localparam int N_RANDOM = 1064;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  slot;
        logic [5:0]  pos;
        logic [31:0] value;
    } op_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  slot;
        logic [5:0]  pos;
        logic [1:0]  status;
    } list_result_t;

    typedef struct {
        op_item_t     item;
        logic         typed;
        list_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [illm_pkg::IN_DATA_W-1:0] s_tdata;
    logic [illm_pkg::OP_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [illm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [illm_pkg::STATUS_W-1:0] m_tuser;

    indexed_linked_list_manager dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Shadow copy of the slot store.
    logic [31:0] sh_value [NSLOT];
    logic [5:0]  sh_next [NSLOT];
    logic [5:0]  sh_prev [NSLOT];
    logic        sh_used [NSLOT];
    logic [5:0]  sh_free [NSLOT];
    int          sh_free_cnt;
    int          sh_free_head;

    list_result_t pending_results[$];
    int  mismatches;
    int  fails;
    longint cycles;
    logic sending_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void list_reset();
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_value[i] = '0;
            sh_next[i] = '0;
            sh_prev[i] = '0;
            sh_used[i] = 1'b0;
            sh_free[i] = '0;
        end
        sh_used[0] = 1'b1;
        for (int i = 1; i < NSLOT; i++)
            sh_free[i-1] = 6'(i);
        sh_free_cnt = NSLOT - 1;
        sh_free_head = 0;
    endfunction

    function automatic list_result_t list_apply(op_item_t it);
        list_result_t r;
        logic [5:0] after;
        logic [5:0] s;
        logic [5:0] nx;
        logic [5:0] cur;
        r = '0;
        r.status = illm_pkg::STATUS_OK;
        case (it.op)
            illm_pkg::OP_INSERT, illm_pkg::OP_PUSH:
            begin
                after = (it.op == illm_pkg::OP_PUSH) ? sh_prev[0] : it.slot;
                if (!sh_used[after])
                    r.status = illm_pkg::STATUS_BAD;
                else if (sh_free_cnt == 0)
                    r.status = illm_pkg::STATUS_FULL;
                else
                begin
                    s = sh_free[sh_free_head];
                    sh_free_head = (sh_free_head + 1) % NSLOT;
                    sh_free_cnt--;
                    nx = sh_next[after];
                    sh_value[s] = it.value;
                    sh_prev[s] = after;
                    sh_next[s] = nx;
                    sh_used[s] = 1'b1;
                    sh_next[after] = s;
                    sh_prev[nx] = s;
                    r.slot = s;
                end
            end
            illm_pkg::OP_REMOVE:
            begin
                s = it.slot;
                if (s == 0 || !sh_used[s])
                    r.status = illm_pkg::STATUS_BAD;
                else
                begin
                    r.value = sh_value[s];
                    sh_next[sh_prev[s]] = sh_next[s];
                    sh_prev[sh_next[s]] = sh_prev[s];
                    sh_next[s] = '0;
                    sh_prev[s] = '0;
                    sh_used[s] = 1'b0;
                    if (sh_free_cnt < NSLOT)
                    begin
                        sh_free[(sh_free_head + sh_free_cnt) % NSLOT] = s;
                        sh_free_cnt++;
                    end
                end
            end
            illm_pkg::OP_FIND:
            begin
                r.status = illm_pkg::STATUS_NOT_FOUND;
                cur = sh_next[0];
                for (int i = 1; cur != 0 && i < NSLOT; i++)
                begin
                    if (sh_value[cur] == it.value)
                    begin
                        r.slot = cur;
                        r.pos = 6'(i);
                        r.status = illm_pkg::STATUS_OK;
                        break;
                    end
                    cur = sh_next[cur];
                end
            end
            illm_pkg::OP_READ:
            begin
                if (it.slot == 0 || !sh_used[it.slot])
                    r.status = illm_pkg::STATUS_BAD;
                else
                    r.value = sh_value[it.slot];
            end
            illm_pkg::OP_READ_POS:
            begin
                cur = '0;
                for (int i = 0; i < it.pos; i++)
                    cur = sh_next[cur];
                if (cur == 0)
                    r.status = illm_pkg::STATUS_NOT_FOUND;
                else
                    r.value = sh_value[cur];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic op_item_t mk(logic [2:0] op, logic [5:0] sl, logic [5:0] ps,
                                    logic [31:0] v);
        op_item_t it;
        it.op = op;
        it.slot = sl;
        it.pos = ps;
        it.value = v;
        return it;
    endfunction

    function automatic list_result_t rs(logic [31:0] v, logic [5:0] sl, logic [5:0] ps,
                                        logic [1:0] st);
        list_result_t r;
        r.value = v;
        r.slot = sl;
        r.pos = ps;
        r.status = st;
        return r;
    endfunction

    // Pick an in-use slot other than the sentinel, or slot 0 if the list is empty.
    function automatic logic [5:0] pick_used();
        logic [5:0] s;
        for (int k = 0; k < 8; k++)
        begin
            s = 6'($urandom_range(1, NSLOT - 1));
            if (sh_used[s])
                return s;
        end
        return sh_next[0];
    endfunction

    function automatic logic [31:0] pick_value();
        logic [5:0] s;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2:
            begin
                s = pick_used();
                return sh_value[s];
            end
            default: return $urandom;
        endcase
    endfunction

    // Sender: predicts at acceptance and pushes the expected result.
    task automatic send_item(op_item_t it, logic typed, list_result_t typed_res);
        list_result_t r;
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {4'b0, it.value, it.pos, it.slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = list_apply(it);
        if (typed && r !== typed_res)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row mismatch op=%0d: expected %h, predicted %h",
                         it.op, typed_res, r);
        end
        pending_results.push_back(r);
    endtask

    initial
    begin
        stim_row_t rows[$];
        op_item_t it;
        int kind;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        fails = 0;
        sending_done = 1'b0;
        list_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; reads of never-written slots stay clear of the store.
        rows.push_back('{mk(illm_pkg::OP_READ_POS, 0, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_NOT_FOUND)});
        rows.push_back('{mk(illm_pkg::OP_FIND, 0, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_NOT_FOUND)});
        rows.push_back('{mk(illm_pkg::OP_READ, 0, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_BAD)});
        rows.push_back('{mk(illm_pkg::OP_REMOVE, 0, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_BAD)});
        rows.push_back('{mk(illm_pkg::OP_REMOVE, 63, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_BAD)});
        rows.push_back('{mk(illm_pkg::OP_INSERT, 5, 0, 1), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_BAD)});
        rows.push_back('{mk(illm_pkg::OP_PUSH, 0, 0, 32'h7fff_ffff), 1,
                         rs(0, 1, 0, illm_pkg::STATUS_OK)});
        rows.push_back('{mk(illm_pkg::OP_INSERT, 0, 63, 32'h8000_0000), 1,
                         rs(0, 2, 0, illm_pkg::STATUS_OK)});
        rows.push_back('{mk(illm_pkg::OP_INSERT, 1, 0, 32'hffff_ffff), 1,
                         rs(0, 3, 0, illm_pkg::STATUS_OK)});
        rows.push_back('{mk(illm_pkg::OP_FIND, 0, 0, 32'hffff_ffff), 0, '0});
        rows.push_back('{mk(illm_pkg::OP_READ_POS, 0, 1, 0), 0, '0});
        rows.push_back('{mk(illm_pkg::OP_READ_POS, 0, 4, 0), 0, '0});
        rows.push_back('{mk(illm_pkg::OP_READ_POS, 0, 5, 0), 0, '0});
        rows.push_back('{mk(illm_pkg::OP_READ_POS, 0, 63, 0), 0, '0});
        rows.push_back('{mk(illm_pkg::OP_READ, 1, 0, 0), 1,
                         rs(32'h7fff_ffff, 0, 0, illm_pkg::STATUS_OK)});
        rows.push_back('{mk(3'd6, 63, 63, 32'hffff_ffff), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_OK)});
        rows.push_back('{mk(3'd7, 1, 1, 1), 1, rs(0, 0, 0, illm_pkg::STATUS_OK)});
        rows.push_back('{mk(illm_pkg::OP_REMOVE, 2, 0, 0), 1,
                         rs(32'h8000_0000, 0, 0, illm_pkg::STATUS_OK)});
        rows.push_back('{mk(illm_pkg::OP_REMOVE, 2, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_BAD)});
        rows.push_back('{mk(illm_pkg::OP_READ, 2, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_BAD)});
        rows.push_back('{mk(illm_pkg::OP_INSERT, 2, 0, 0), 1,
                         rs(0, 0, 0, illm_pkg::STATUS_BAD)});
        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].res);
        // Fill the store to the brim, then one more each way to hit the full status.
        for (int i = 0; i < 62; i++)
            send_item(mk(illm_pkg::OP_PUSH, 6'($urandom), 6'($urandom), $urandom), 0, '0);
        send_item(mk(illm_pkg::OP_PUSH, 0, 0, 0), 1, rs(0, 0, 0, illm_pkg::STATUS_FULL));
        send_item(mk(illm_pkg::OP_INSERT, 0, 0, 0), 1, rs(0, 0, 0, illm_pkg::STATUS_FULL));
        send_item(mk(illm_pkg::OP_READ_POS, 0, 63, 0), 0, '0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Bias inserts against removes in slow waves so the list sweeps empty to full.
            kind = $urandom_range(0, 99);
            if (((n / 200) % 2) == 1)
                kind = (kind < 40) ? 60 : kind;
            it = mk(3'($urandom), 6'($urandom), 6'($urandom), pick_value());
            if (kind < 25)
                it.op = illm_pkg::OP_PUSH;
            else if (kind < 45)
            begin
                it.op = illm_pkg::OP_INSERT;
                if ($urandom_range(0, 4) != 0)
                    it.slot = ($urandom_range(0, 3) == 0) ? 6'd0 : pick_used();
            end
            else if (kind < 70)
            begin
                it.op = illm_pkg::OP_REMOVE;
                if ($urandom_range(0, 4) != 0)
                    it.slot = pick_used();
            end
            else if (kind < 80)
                it.op = illm_pkg::OP_FIND;
            else if (kind < 88)
            begin
                it.op = illm_pkg::OP_READ;
                if ($urandom_range(0, 4) != 0)
                    it.slot = pick_used();
            end
            else if (kind < 97)
                it.op = illm_pkg::OP_READ_POS;
            // A read of a free slot must never touch a store word that was never written.
            if (it.op == illm_pkg::OP_READ && !sh_used[it.slot])
                it.slot = (sh_next[0] == 0) ? 6'd0 : it.slot;
            send_item(it, 0, '0);
        end
        s_tvalid <= 1'b0;
        sending_done <= 1'b1;
    end

    // Receiver with random stalls and one long hold-off.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        // Long hold-off so the block fills up and stalls its input.
        repeat (300) @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = rs(m_tdata[31:0], m_tdata[37:32], m_tdata[43:38], m_tuser);
            if (pending_results.size() == 0)
            begin
                fails++;
                $display("unexpected result %h", got);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected value=%h slot=%0d pos=%0d status=%0d,",
                                  " got value=%h slot=%0d pos=%0d status=%0d"},
                                 exp_r.value, exp_r.slot, exp_r.pos, exp_r.status,
                                 got.value, got.slot, got.pos, got.status);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        wait (sending_done === 1'b1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (fails == 0 && mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
